// File: rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants of the timed setpoint schedule queue
// Holds the store depths, transaction structs, cell and chain controls and
// the controller state type.
// ----------------------------------------------------------------------------
package tsq_pkg;

  // store depths and derived widths
  localparam int SCHED_DEPTH = 16;
  localparam int PEND_DEPTH  = 8;
  localparam int SCHED_CNT_W = $clog2(SCHED_DEPTH + 1);
  localparam int PEND_CNT_W  = $clog2(PEND_DEPTH + 1);

  // action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_COMMIT = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_PEND_FULL = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  // input transaction
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] stamp;
    logic [31:0] payload;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic                   front_valid;
    logic [31:0]            front_time;
    logic [31:0]            front_value;
    logic [SCHED_CNT_W-1:0] scheduled_count;
    logic [PEND_CNT_W-1:0]  pending_count;
    logic [1:0]             error_code;
  } out_item_t;

  // one stored setpoint
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] value;
  } entry_t;

  // what a cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  // pending chain control
  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } pend_ctl_t;

  // pending chain status
  typedef struct packed {
    entry_t                head;
    logic [PEND_CNT_W-1:0] fill;
    logic                  full;
  } pend_sts_t;

  // schedule chain control
  typedef struct packed {
    logic append;
    logic pop;
    logic trim;
  } sched_ctl_t;

  // schedule chain status
  typedef struct packed {
    entry_t                 head;
    logic [SCHED_CNT_W-1:0] fill;
    logic                   full;
    logic                   trim_hit;
  } sched_sts_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TRIM,
    ST_APPEND,
    ST_TICK,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/timed_setpoint_schedule_queue_top.sv
// ----------------------------------------------------------------------------
// timed_setpoint_schedule_queue_top: timed setpoint schedule queue
// Pending and schedule stores as rows of shifting cells under one controller;
// add, commit and tick transactions each return one status result.
// ----------------------------------------------------------------------------
//
//   channel  ports                        moves
//   in       in_valid in_ready in_data    action, stamp, payload
//   out      out_valid out_ready out_data front, counts, error code
//
// One transaction is worked at a time; the controller walks the cell rows.
// Add inserts into the pending store, tick pops expired schedule entries and
// commit trims the schedule tail, then appends the pending entries, doing
// neither when nothing is pending. A finished result waits in the output
// register while the next transaction is taken; a stalled output holds back
// only the following result. Reset is synchronous, active low, empties both.
// ----------------------------------------------------------------------------
module timed_setpoint_schedule_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tsq_pkg::out_item_t out_data
);

  tsq_pkg::state_t     state_r;
  tsq_pkg::state_t     state_nxt;
  tsq_pkg::in_item_t   cmd_r;
  logic                cmd_load;
  logic [1:0]          err_r;
  logic [1:0]          err_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  tsq_pkg::out_item_t  out_data_r;
  tsq_pkg::out_item_t  result;
  logic                out_load;
  logic                tick_hit;
  tsq_pkg::pend_ctl_t  pend_ctl;
  tsq_pkg::pend_sts_t  pend_sts;
  tsq_pkg::sched_ctl_t sched_ctl;
  tsq_pkg::sched_sts_t sched_sts;
  tsq_pkg::entry_t     cmd_entry;

  assign cmd_entry.stamp = cmd_r.stamp;
  assign cmd_entry.value = cmd_r.payload;

  // pending store
  tsq_pend_chain u_pend (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pend_ctl),
    .new_i (cmd_entry),
    .sts   (pend_sts)
  );

  // schedule store
  tsq_sched_chain u_sched (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sched_ctl),
    .append_i (pend_sts.head),
    .trim_key (pend_sts.head.stamp),
    .sts      (sched_sts)
  );

  assign tick_hit = (sched_sts.fill != '0) && (sched_sts.head.stamp <= cmd_r.stamp);

  // next state and chain controls
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    in_ready  = 1'b0;
    cmd_load  = 1'b0;
    out_load  = 1'b0;
    pend_ctl  = '0;
    sched_ctl = '0;
    case (state_r)
      tsq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_load = 1'b1;
          err_nxt  = tsq_pkg::ERR_NONE;
          case (in_data.action)
            tsq_pkg::ACT_ADD:    state_nxt = tsq_pkg::ST_ADD;
            tsq_pkg::ACT_COMMIT: state_nxt = tsq_pkg::ST_TRIM;
            tsq_pkg::ACT_TICK:   state_nxt = tsq_pkg::ST_TICK;
            default:             state_nxt = tsq_pkg::ST_FINISH;
          endcase
        end
      end
      tsq_pkg::ST_ADD: begin
        if (pend_sts.full) begin
          err_nxt = tsq_pkg::ERR_PEND_FULL;
        end else begin
          pend_ctl.insert = 1'b1;
        end
        state_nxt = tsq_pkg::ST_FINISH;
      end
      tsq_pkg::ST_TRIM: begin
        if (pend_sts.fill == '0) begin
          state_nxt = tsq_pkg::ST_FINISH;
        end else if (sched_sts.trim_hit) begin
          sched_ctl.trim = 1'b1;
        end else begin
          state_nxt = tsq_pkg::ST_APPEND;
        end
      end
      tsq_pkg::ST_APPEND: begin
        if (pend_sts.fill == '0) begin
          state_nxt = tsq_pkg::ST_FINISH;
        end else if (sched_sts.full) begin
          // schedule overflow, rest of the pending entries are dropped
          err_nxt        = tsq_pkg::ERR_OVERFLOW;
          pend_ctl.clear = 1'b1;
          state_nxt      = tsq_pkg::ST_FINISH;
        end else begin
          sched_ctl.append = 1'b1;
          pend_ctl.pop     = 1'b1;
        end
      end
      tsq_pkg::ST_TICK: begin
        if (tick_hit) begin
          sched_ctl.pop = 1'b1;
        end else begin
          state_nxt = tsq_pkg::ST_FINISH;
        end
      end
      tsq_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = tsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsq_pkg::ST_IDLE;
      end
    endcase
  end

  // result assembly
  always_comb begin
    result.front_valid     = (sched_sts.fill != '0);
    result.front_time      = result.front_valid ? sched_sts.head.stamp : 32'd0;
    result.front_value     = result.front_valid ? sched_sts.head.value : 32'd0;
    result.scheduled_count = sched_sts.fill;
    result.pending_count   = pend_sts.fill;
    result.error_code      = err_r;
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsq_pkg::ST_IDLE;
      err_r       <= tsq_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // fill counts never exceed the store depths
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_sts.fill <= tsq_pkg::PEND_CNT_W'(tsq_pkg::PEND_DEPTH)) &&
    (sched_sts.fill <= tsq_pkg::SCHED_CNT_W'(tsq_pkg::SCHED_DEPTH)))
    else $error("store fill count beyond depth");

  // an add into a full pending store leaves it untouched
  a_add_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsq_pkg::ST_ADD && pend_sts.full) |=>
    (pend_sts.fill == $past(pend_sts.fill)) && (err_r == tsq_pkg::ERR_PEND_FULL))
    else $error("add into full pending store changed it");

  // a commit always leaves the pending store empty
  a_commit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsq_pkg::ST_APPEND && state_nxt == tsq_pkg::ST_FINISH) |=>
    (pend_sts.fill == '0))
    else $error("pending store not empty after commit");

  // a tick never grows the schedule
  a_tick_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsq_pkg::ST_TICK) |=> (sched_sts.fill <= $past(sched_sts.fill)))
    else $error("schedule grew during tick");
`endif

endmodule

// File: rtl/tsq_cell.sv
// ----------------------------------------------------------------------------
// tsq_cell: one storage cell of a setpoint chain
// Holds one time and value pair; keeps it, loads an external entry or takes
// the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module tsq_cell (
  input  logic              clk,
  input  tsq_pkg::cell_op_t op,
  input  tsq_pkg::entry_t   ext_i,
  input  tsq_pkg::entry_t   left_i,
  input  tsq_pkg::entry_t   right_i,
  output tsq_pkg::entry_t   entry_o
);

  tsq_pkg::entry_t entry_r;
  tsq_pkg::entry_t entry_nxt;

  // next entry select
  always_comb begin
    case (op)
      tsq_pkg::CELL_HOLD:  entry_nxt = entry_r;
      tsq_pkg::CELL_LOAD:  entry_nxt = ext_i;
      tsq_pkg::CELL_LEFT:  entry_nxt = left_i;
      tsq_pkg::CELL_RIGHT: entry_nxt = right_i;
      default:             entry_nxt = entry_r;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

// File: rtl/tsq_pend_chain.sv
// ----------------------------------------------------------------------------
// tsq_pend_chain: pending store kept in time order
// Each add slides the later cells one place right so the chain stays sorted,
// equal times in arrival order; pop shifts the chain one place left.
// ----------------------------------------------------------------------------
module tsq_pend_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  tsq_pkg::pend_ctl_t ctl,
  input  tsq_pkg::entry_t    new_i,
  output tsq_pkg::pend_sts_t sts
);

  localparam int N = tsq_pkg::PEND_DEPTH;
  localparam int W = tsq_pkg::PEND_CNT_W;

  logic [W-1:0]      fill_r;
  logic [W-1:0]      fill_nxt;
  logic              full;
  logic [N-1:0]      le;
  tsq_pkg::entry_t   cells [N];
  tsq_pkg::cell_op_t ops   [N];

  assign full = (fill_r == W'(N));

  // per-cell insert compare, true for occupied cells not later than the new one
  for (genvar i = 0; i < N; i++) begin : g_cmp
    assign le[i] = (W'(i) < fill_r) && (cells[i].stamp <= new_i.stamp);
  end

  // per-cell control
  for (genvar i = 0; i < N; i++) begin : g_op
    always_comb begin
      ops[i] = tsq_pkg::CELL_HOLD;
      if (ctl.insert && !full) begin
        if (le[i]) begin
          ops[i] = tsq_pkg::CELL_HOLD;
        end else if (i == 0) begin
          ops[i] = tsq_pkg::CELL_LOAD;
        end else if (le[(i > 0) ? i - 1 : 0]) begin
          ops[i] = tsq_pkg::CELL_LOAD;
        end else begin
          ops[i] = tsq_pkg::CELL_LEFT;
        end
      end else if (ctl.pop && (i < N - 1)) begin
        ops[i] = tsq_pkg::CELL_RIGHT;
      end
    end
  end

  // the row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    tsq_cell u_cell (
      .clk     (clk),
      .op      (ops[i]),
      .ext_i   (new_i),
      .left_i  (cells[(i > 0) ? i - 1 : 0]),
      .right_i (cells[(i < N - 1) ? i + 1 : i]),
      .entry_o (cells[i])
    );
  end

  // fill count
  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clear) begin
      fill_nxt = '0;
    end else if (ctl.insert && !full) begin
      fill_nxt = fill_r + W'(1);
    end else if (ctl.pop && (fill_r != '0)) begin
      fill_nxt = fill_r - W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign sts.head = cells[0];
  assign sts.fill = fill_r;
  assign sts.full = full;

endmodule

// File: rtl/tsq_sched_chain.sv
// ----------------------------------------------------------------------------
// tsq_sched_chain: schedule kept in ascending time order
// Appends at the tail, pops at the head with a one-place left shift and
// trims the tail one entry per cycle while it is at or after the trim key.
// ----------------------------------------------------------------------------
module tsq_sched_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  tsq_pkg::sched_ctl_t ctl,
  input  tsq_pkg::entry_t     append_i,
  input  logic [31:0]         trim_key,
  output tsq_pkg::sched_sts_t sts
);

  localparam int N = tsq_pkg::SCHED_DEPTH;
  localparam int W = tsq_pkg::SCHED_CNT_W;

  logic [W-1:0]      fill_r;
  logic [W-1:0]      fill_nxt;
  logic              full;
  logic [N-1:0]      ge;
  tsq_pkg::entry_t   cells [N];
  tsq_pkg::cell_op_t ops   [N];

  assign full = (fill_r == W'(N));

  // occupied cells at or after the trim key form a suffix of the occupied ones
  for (genvar i = 0; i < N; i++) begin : g_cmp
    assign ge[i] = (W'(i) < fill_r) && (cells[i].stamp >= trim_key);
  end

  // per-cell control
  for (genvar i = 0; i < N; i++) begin : g_op
    always_comb begin
      ops[i] = tsq_pkg::CELL_HOLD;
      if (ctl.append && (fill_r == W'(i))) begin
        ops[i] = tsq_pkg::CELL_LOAD;
      end else if (ctl.pop && (i < N - 1)) begin
        ops[i] = tsq_pkg::CELL_RIGHT;
      end
    end
  end

  // the row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    tsq_cell u_cell (
      .clk     (clk),
      .op      (ops[i]),
      .ext_i   (append_i),
      .left_i  (cells[(i > 0) ? i - 1 : 0]),
      .right_i (cells[(i < N - 1) ? i + 1 : i]),
      .entry_o (cells[i])
    );
  end

  // fill count
  always_comb begin
    fill_nxt = fill_r;
    if (ctl.append && !full) begin
      fill_nxt = fill_r + W'(1);
    end else if ((ctl.pop || (ctl.trim && (|ge))) && (fill_r != '0)) begin
      fill_nxt = fill_r - W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign sts.head     = cells[0];
  assign sts.fill     = fill_r;
  assign sts.full     = full;
  assign sts.trim_hit = |ge;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the timed setpoint schedule queue
// A table of directed transactions covers the empty, full, tie and overflow
// corners. Random add batches, commits, ticks and no-ops follow. Every result
// is checked field by field against its table row or a model of both stores.
// ----------------------------------------------------------------------------
module testbench;

  // unused action code, the block treats it as a no-op
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam int ITEM_TARGET  = 850;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIRECTED_CNT = 26;
  localparam int PEND_IDX_W   = $clog2(tsq_pkg::PEND_DEPTH);
  localparam int SCHED_IDX_W  = $clog2(tsq_pkg::SCHED_DEPTH);

  typedef struct {
    tsq_pkg::in_item_t  cmd;
    bit                 typed;
    tsq_pkg::out_item_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tsq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tsq_pkg::out_item_t out_data;

  // model of the pending store and the schedule
  logic [31:0]                     pend_time [tsq_pkg::PEND_DEPTH];
  logic [31:0]                     pend_val  [tsq_pkg::PEND_DEPTH];
  logic [tsq_pkg::PEND_CNT_W-1:0]  pend_fill;
  logic [31:0]                     sched_time[tsq_pkg::SCHED_DEPTH];
  logic [31:0]                     sched_val [tsq_pkg::SCHED_DEPTH];
  logic [tsq_pkg::SCHED_CNT_W-1:0] sched_fill;

  tsq_pkg::out_item_t status_q[$];
  stim_row_t          directed_rows[DIRECTED_CNT];
  int                 fail_count = 0;
  int                 items_sent;
  int                 cycle_cnt = 0;
  bit                 in_calm;
  bit                 out_calm;

  timed_setpoint_schedule_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tsq_pkg::out_item_t status_of(logic fv, logic [31:0] ft,
                                                   logic [31:0] fval,
                                                   logic [tsq_pkg::SCHED_CNT_W-1:0] sc,
                                                   logic [tsq_pkg::PEND_CNT_W-1:0] pc,
                                                   logic [1:0] ec);
    tsq_pkg::out_item_t s;
    s.front_valid     = fv;
    s.front_time      = ft;
    s.front_value     = fval;
    s.scheduled_count = sc;
    s.pending_count   = pc;
    s.error_code      = ec;
    return s;
  endfunction

  function automatic stim_row_t cmd_row(logic [1:0] act, logic [31:0] stamp,
                                        logic [31:0] payload, bit typed,
                                        tsq_pkg::out_item_t want);
    stim_row_t r;
    r.cmd.action  = act;
    r.cmd.stamp   = stamp;
    r.cmd.payload = payload;
    r.typed       = typed;
    r.want        = want;
    return r;
  endfunction

  // apply one transaction to the store model and form its status
  task automatic predict_status(input tsq_pkg::in_item_t cmd,
                                output tsq_pkg::out_item_t res);
    logic [31:0] t;
    logic [31:0] v;
    logic [31:0] earliest;
    logic [1:0]  err;
    int          i;
    int          j;
    int          n;
    err = tsq_pkg::ERR_NONE;
    case (cmd.action)
      tsq_pkg::ACT_ADD: begin
        if (pend_fill >= tsq_pkg::PEND_DEPTH) begin
          err = tsq_pkg::ERR_PEND_FULL;
        end else begin
          pend_time[pend_fill[PEND_IDX_W-1:0]] = cmd.stamp;
          pend_val[pend_fill[PEND_IDX_W-1:0]]  = cmd.payload;
          pend_fill++;
        end
      end
      tsq_pkg::ACT_COMMIT: begin
        if (pend_fill != 0) begin
          // stable sort of pending by time
          for (i = 1; i < pend_fill; i++) begin
            t = pend_time[i];
            v = pend_val[i];
            j = i;
            while (j > 0 && pend_time[j-1] > t) begin
              pend_time[j] = pend_time[j-1];
              pend_val[j]  = pend_val[j-1];
              j--;
            end
            pend_time[j] = t;
            pend_val[j]  = v;
          end
          // drop scheduled entries at or after the earliest pending time
          earliest = pend_time[0];
          n = 0;
          while (n < sched_fill && sched_time[n] < earliest) n++;
          sched_fill = tsq_pkg::SCHED_CNT_W'(n);
          // append, the latest fall off when the schedule is full
          for (i = 0; i < pend_fill; i++) begin
            if (sched_fill >= tsq_pkg::SCHED_DEPTH) begin
              err = tsq_pkg::ERR_OVERFLOW;
              break;
            end
            sched_time[sched_fill[SCHED_IDX_W-1:0]] = pend_time[i];
            sched_val[sched_fill[SCHED_IDX_W-1:0]]  = pend_val[i];
            sched_fill++;
          end
          pend_fill = '0;
        end
      end
      tsq_pkg::ACT_TICK: begin
        n = 0;
        while (n < sched_fill && sched_time[n] <= cmd.stamp) n++;
        for (i = n; i < sched_fill; i++) begin
          sched_time[i-n] = sched_time[i];
          sched_val[i-n]  = sched_val[i];
        end
        sched_fill = sched_fill - tsq_pkg::SCHED_CNT_W'(n);
      end
      default: ;
    endcase
    if (sched_fill != 0)
      res = status_of(1'b1, sched_time[0], sched_val[0], sched_fill, pend_fill, err);
    else
      res = status_of(1'b0, '0, '0, sched_fill, pend_fill, err);
  endtask

  // drive one transaction and record what it should return
  task automatic send_cmd(input tsq_pkg::in_item_t cmd, input bit typed,
                          input tsq_pkg::out_item_t want);
    int                 gap;
    tsq_pkg::out_item_t predicted;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_status(cmd, predicted);
    status_q.insert(status_q.size(), typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // result side stalls
  initial begin : ready_gen
    int stall;
    out_ready = 1'b0;
    out_calm  = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
      stall = pick_gap(out_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    tsq_pkg::out_item_t exp_s;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (status_q.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        fail_count++;
      end else begin
        exp_s = status_q[0];
        status_q.delete(0);
        if (out_data.front_valid !== exp_s.front_valid) begin
          $error("front_valid: expected %0d, got %0d", exp_s.front_valid, out_data.front_valid);
          fail_count++;
        end
        if (out_data.front_time !== exp_s.front_time) begin
          $error("front_time: expected %h, got %h", exp_s.front_time, out_data.front_time);
          fail_count++;
        end
        if (out_data.front_value !== exp_s.front_value) begin
          $error("front_value: expected %h, got %h", exp_s.front_value, out_data.front_value);
          fail_count++;
        end
        if (out_data.scheduled_count !== exp_s.scheduled_count) begin
          $error("scheduled_count: expected %0d, got %0d", exp_s.scheduled_count,
                 out_data.scheduled_count);
          fail_count++;
        end
        if (out_data.pending_count !== exp_s.pending_count) begin
          $error("pending_count: expected %0d, got %0d", exp_s.pending_count,
                 out_data.pending_count);
          fail_count++;
        end
        if (out_data.error_code !== exp_s.error_code) begin
          $error("error_code: expected %0d, got %0d", exp_s.error_code, out_data.error_code);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stim
    tsq_pkg::out_item_t idle_s;
    tsq_pkg::in_item_t  cmd;
    logic [31:0]        now_ms;
    logic [31:0]        horizon;
    logic [31:0]        last_stamp;
    int                 r;
    int                 n;
    bit                 ascending;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    in_calm    = 1'b0;
    items_sent = 0;
    pend_fill  = '0;
    sched_fill = '0;
    idle_s     = status_of(1'b0, '0, '0, 5'd0, 4'd0, tsq_pkg::ERR_NONE);

    // directed rows: empty store, extremes, ties, pending full, overflow
    directed_rows[0]  = cmd_row(tsq_pkg::ACT_TICK,   32'h0,         32'hFFFF_FFFF, 1'b1, idle_s);
    directed_rows[1]  = cmd_row(tsq_pkg::ACT_COMMIT, 32'h0,         32'h0,         1'b1, idle_s);
    directed_rows[2]  = cmd_row(ACT_NOP,             32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, idle_s);
    directed_rows[3]  = cmd_row(tsq_pkg::ACT_ADD,    32'h0,         32'hFFFF_FFFF, 1'b1,
                                status_of(1'b0, '0, '0, 5'd0, 4'd1, tsq_pkg::ERR_NONE));
    directed_rows[4]  = cmd_row(tsq_pkg::ACT_ADD,    32'd100,       32'hA5A5_A5A5, 1'b0, '0);
    directed_rows[5]  = cmd_row(tsq_pkg::ACT_ADD,    32'd100,       32'h5A5A_5A5A, 1'b0, '0);
    directed_rows[6]  = cmd_row(tsq_pkg::ACT_ADD,    32'd50,        32'h1234_5678, 1'b0, '0);
    directed_rows[7]  = cmd_row(tsq_pkg::ACT_ADD,    32'd100,       32'h0000_0001, 1'b0, '0);
    directed_rows[8]  = cmd_row(tsq_pkg::ACT_ADD,    32'd7,         32'h0,         1'b0, '0);
    directed_rows[9]  = cmd_row(tsq_pkg::ACT_ADD,    32'd3,         32'h89AB_CDEF, 1'b0, '0);
    directed_rows[10] = cmd_row(tsq_pkg::ACT_ADD,    32'd1000,      32'hFEDC_BA98, 1'b0, '0);
    directed_rows[11] = cmd_row(tsq_pkg::ACT_ADD,    32'd9,         32'hDEAD_BEEF, 1'b1,
                                status_of(1'b0, '0, '0, 5'd0, 4'd8, tsq_pkg::ERR_PEND_FULL));
    directed_rows[12] = cmd_row(tsq_pkg::ACT_COMMIT, 32'h0,         32'h0,         1'b0, '0);
    directed_rows[13] = cmd_row(tsq_pkg::ACT_ADD,    32'd2000,      32'h1111_1111, 1'b0, '0);
    directed_rows[14] = cmd_row(tsq_pkg::ACT_COMMIT, 32'h0,         32'h0,         1'b0, '0);
    directed_rows[15] = cmd_row(tsq_pkg::ACT_ADD,    32'd3000,      32'h2222_2222, 1'b0, '0);
    directed_rows[16] = cmd_row(tsq_pkg::ACT_ADD,    32'd3000,      32'h3333_3333, 1'b0, '0);
    directed_rows[17] = cmd_row(tsq_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    directed_rows[18] = cmd_row(tsq_pkg::ACT_ADD,    32'd3001,      32'h4444_4444, 1'b0, '0);
    directed_rows[19] = cmd_row(tsq_pkg::ACT_ADD,    32'd2500,      32'h5555_5555, 1'b0, '0);
    directed_rows[20] = cmd_row(tsq_pkg::ACT_ADD,    32'd4000,      32'h6666_6666, 1'b0, '0);
    directed_rows[21] = cmd_row(tsq_pkg::ACT_ADD,    32'd3500,      32'h7777_7777, 1'b0, '0);
    directed_rows[22] = cmd_row(tsq_pkg::ACT_ADD,    32'd3002,      32'h8888_8888, 1'b0, '0);
    directed_rows[23] = cmd_row(tsq_pkg::ACT_COMMIT, 32'h0,         32'h0,         1'b0, '0);
    directed_rows[24] = cmd_row(tsq_pkg::ACT_TICK,   32'd100,       32'h0,         1'b0, '0);
    directed_rows[25] = cmd_row(tsq_pkg::ACT_TICK,   32'hFFFF_FFFF, 32'h0,         1'b1, idle_s);

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_CNT; i++)
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // random part: add batches then commit, ticks, some noise
    now_ms     = $urandom_range(0, 1000);
    horizon    = now_ms;
    last_stamp = now_ms;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
      r = $urandom_range(0, 99);
      if (r < 62) begin
        // batch of adds, sometimes more than the pending store holds
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        ascending = ($urandom_range(0, 1) != 0);
        repeat (n) begin
          cmd.action  = tsq_pkg::ACT_ADD;
          cmd.payload = $urandom;
          r = $urandom_range(0, 99);
          if (ascending) begin
            horizon   = horizon + $urandom_range(0, 40);
            cmd.stamp = horizon;
          end else if (r < 70) begin
            cmd.stamp = now_ms + $urandom_range(0, 300);
          end else if (r < 90) begin
            cmd.stamp = last_stamp;
          end else begin
            cmd.stamp = $urandom;
          end
          if (!ascending && cmd.stamp > horizon && r < 90) horizon = cmd.stamp;
          last_stamp = cmd.stamp;
          send_cmd(cmd, 1'b0, '0);
        end
        if ($urandom_range(0, 99) < 85) begin
          cmd.action  = tsq_pkg::ACT_COMMIT;
          cmd.stamp   = $urandom;
          cmd.payload = $urandom;
          send_cmd(cmd, 1'b0, '0);
        end
      end else if (r < 88) begin
        // advance time and expire
        r = $urandom_range(0, 99);
        if (r < 10)
          now_ms = horizon - $urandom_range(0, 100);
        else
          now_ms = now_ms + $urandom_range(0, 120);
        cmd.action  = tsq_pkg::ACT_TICK;
        cmd.stamp   = (r > 95) ? $urandom : now_ms;
        cmd.payload = $urandom;
        send_cmd(cmd, 1'b0, '0);
      end else begin
        // noise: no-op, stray commit or tick with any time
        r = $urandom_range(0, 2);
        cmd.action  = (r == 0) ? ACT_NOP :
                      (r == 1) ? tsq_pkg::ACT_COMMIT : tsq_pkg::ACT_TICK;
        cmd.stamp   = $urandom;
        cmd.payload = $urandom;
        send_cmd(cmd, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
